@@ sv/pcd_pkg.sv @@
`timescale 1ns / 1ps
package pcd_pkg;

    // Table geometry
    localparam int MAX_LEN     = 16;
    localparam int NUM_SYMBOLS = 256;
    localparam int OFFS_DEPTH  = MAX_LEN + 2;
    localparam int WIN_W       = 64;

    // Request codes on the input queue
    localparam logic [1:0] REQ_DECODE      = 2'd0;
    localparam logic [1:0] REQ_LOAD_ENTRY  = 2'd1;
    localparam logic [1:0] REQ_LOAD_OFFSET = 2'd2;

    typedef enum logic [1:0] {
        CMD_DECODE,
        CMD_LOAD_ENTRY,
        CMD_LOAD_OFFSET
    } cmd_kind_t;

    // One classified command passed from the front to the back
    typedef struct packed {
        cmd_kind_t    kind;
        logic [63:0]  bits;
        logic [6:0]   wlen;
        logic [7:0]   idx;
        logic [15:0]  codeword;
        logic [7:0]   sym;
        logic [4:0]   level;
        logic [8:0]   offset;
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_OFFS,
        ST_CHK,
        ST_LOW,
        ST_HIGH,
        ST_BS,
        ST_CMP
    } state_t;

endpackage

@@ sv/pcd_front.sv @@
`timescale 1ns / 1ps
module pcd_front (
    input  logic               push,
    input  logic [1:0]         req_type,
    input  logic [63:0]        window_bits,
    input  logic [6:0]         window_len,
    input  logic [7:0]         entry_index,
    input  logic [15:0]        entry_codeword,
    input  logic [7:0]         entry_symbol,
    input  logic [4:0]         offset_level,
    input  logic [8:0]         offset_value,
    input  logic               q_full,
    output logic               q_push,
    output pcd_pkg::cmd_t      q_data
);
    import pcd_pkg::*;

    logic keep;

    // Classify the request and drop those that change nothing.
    always_comb
    begin
        q_data.bits     = window_bits;
        q_data.wlen     = (window_len > 7'(WIN_W)) ? 7'(WIN_W) : window_len;
        q_data.idx      = entry_index;
        q_data.codeword = entry_codeword;
        q_data.sym      = entry_symbol;
        q_data.level    = offset_level;
        q_data.offset   = offset_value;
        q_data.kind     = CMD_DECODE;
        keep            = 1'b0;
        unique case (req_type)
            REQ_DECODE:
            begin
                q_data.kind = CMD_DECODE;
                keep        = 1'b1;
            end
            REQ_LOAD_ENTRY:
            begin
                q_data.kind = CMD_LOAD_ENTRY;
                keep        = 1'b1;
            end
            REQ_LOAD_OFFSET:
            begin
                q_data.kind = CMD_LOAD_OFFSET;
                keep        = (offset_level < 5'(OFFS_DEPTH));
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    // A transfer is taken only while the queue has room.
    assign q_push = push && !q_full && keep;

endmodule

@@ sv/pcd_cmd_fifo.sv @@
`timescale 1ns / 1ps
module pcd_cmd_fifo (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  pcd_pkg::cmd_t      wr_data,
    output logic               full,
    input  logic               rd_en,
    output logic               empty,
    output pcd_pkg::cmd_t      rd_data
);
    import pcd_pkg::*;

    cmd_t       slot_reg [2];
    logic       wptr_reg;
    logic       wptr_next;
    logic       rptr_reg;
    logic       rptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign rd_data = slot_reg[rptr_reg];

    // Pointer and count update.
    always_comb
    begin
        wptr_next  = wptr_reg ^ wr_en;
        rptr_next  = rptr_reg ^ rd_en;
        count_next = count_reg + 2'(wr_en) - 2'(rd_en);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    // Storage for the two queued commands.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_reg[wptr_reg] <= wr_data;
        end
    end

endmodule

@@ sv/pcd_back.sv @@
`timescale 1ns / 1ps
module pcd_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [4:0]         cfg_wdata,
    input  logic               q_empty,
    input  pcd_pkg::cmd_t      q_data,
    output logic               q_pop,
    output logic               empty,
    input  logic               pop,
    output logic [4:0]         matched_len,
    output logic [7:0]         symbol
);
    import pcd_pkg::*;

    // Codeword and symbol table, one read port with registered data
    logic [23:0]        cmem [NUM_SYMBOLS];
    logic [23:0]        cmem_q;
    logic [7:0]         rd_addr;
    // Per-length start offsets, two registered read ports
    logic [8:0]         omem [OFFS_DEPTH];
    logic [8:0]         off_lo_q;
    logic [8:0]         off_hi_q;

    state_t             state_reg;
    state_t             state_next;
    logic [4:0]         mcl_reg;
    logic [4:0]         len_reg;
    logic [4:0]         len_next;
    logic [63:0]        bits_reg;
    logic [6:0]         wlen_reg;
    logic [15:0]        w_reg;
    logic signed [9:0]  lo_reg;
    logic signed [9:0]  lo_next;
    logic signed [9:0]  hi_reg;
    logic signed [9:0]  hi_next;
    logic signed [9:0]  k_reg;
    logic signed [9:0]  k_val;
    logic               res_valid_reg;
    logic [4:0]         res_len_reg;
    logic [7:0]         res_sym_reg;

    logic               slot_free;
    logic               start_dec;
    logic [4:0]         top;
    logic               res_wr;
    logic [4:0]         res_len;
    logic [7:0]         res_sym;
    logic               skip;
    logic               bad_group;
    logic [63:0]        shifted;
    logic [15:0]        w_val;
    logic [15:0]        cw;

    assign slot_free   = !res_valid_reg || pop;
    assign empty       = !res_valid_reg;
    assign matched_len = res_len_reg;
    assign symbol      = res_sym_reg;
    assign cw          = cmem_q[23:8];

    // Longest length worth probing for the command at the queue head.
    always_comb
    begin
        top = (q_data.wlen > 7'(MAX_LEN)) ? 5'(MAX_LEN) : q_data.wlen[4:0];
        if (top > mcl_reg)
        begin
            top = mcl_reg;
        end
    end

    // Window prefix of the current length.
    always_comb
    begin
        shifted = bits_reg >> (6'(wlen_reg - 7'(len_reg)));
        w_val   = shifted[15:0] & 16'((17'd1 << len_reg) - 17'd1);
    end

    assign bad_group = (off_lo_q >= off_hi_q) || (off_hi_q > 9'(NUM_SYMBOLS));
    assign k_val     = lo_reg + ((hi_reg - lo_reg) >>> 1);

    function automatic logic skip_end();
        skip_end = (len_reg == 5'd1);
    endfunction

    // Next state of the search sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start_dec && top != 5'd0)
                begin
                    state_next = ST_OFFS;
                end
            end
            ST_OFFS: state_next = ST_CHK;
            ST_CHK:  state_next = bad_group ? (skip_end() ? ST_IDLE : ST_OFFS) : ST_LOW;
            ST_LOW:  state_next = (w_reg < cw) ? (skip_end() ? ST_IDLE : ST_OFFS) : ST_HIGH;
            ST_HIGH: state_next = (cw < w_reg) ? (skip_end() ? ST_IDLE : ST_OFFS) : ST_BS;
            ST_BS:   state_next = (lo_reg > hi_reg) ? (skip_end() ? ST_IDLE : ST_OFFS) : ST_CMP;
            ST_CMP:  state_next = (cw == w_reg) ? ST_IDLE : ST_BS;
            default: state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs: queue pop, table address, result write.
    always_comb
    begin
        q_pop     = 1'b0;
        start_dec = 1'b0;
        rd_addr   = lo_reg[7:0];
        res_wr    = 1'b0;
        res_len   = 5'd0;
        res_sym   = 8'd0;
        skip      = 1'b0;
        len_next  = len_reg;
        lo_next   = lo_reg;
        hi_next   = hi_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    if (q_data.kind != CMD_DECODE)
                    begin
                        q_pop = 1'b1;
                    end
                    else if (slot_free)
                    begin
                        q_pop     = 1'b1;
                        start_dec = 1'b1;
                        len_next  = top;
                        res_wr    = (top == 5'd0);
                    end
                end
            end
            ST_OFFS:
            begin
            end
            ST_CHK:
            begin
                skip    = bad_group;
                rd_addr = off_lo_q[7:0];
                lo_next = 10'(off_lo_q);
                hi_next = 10'(off_hi_q) - 10'sd1;
            end
            ST_LOW:
            begin
                skip    = (w_reg < cw);
                rd_addr = hi_reg[7:0];
            end
            ST_HIGH:
            begin
                skip = (cw < w_reg);
            end
            ST_BS:
            begin
                skip    = (lo_reg > hi_reg);
                rd_addr = k_val[7:0];
            end
            ST_CMP:
            begin
                if (cw == w_reg)
                begin
                    res_wr  = 1'b1;
                    res_len = len_reg;
                    res_sym = cmem_q[7:0];
                end
                else if (cw < w_reg)
                begin
                    lo_next = k_reg + 10'sd1;
                end
                else
                begin
                    hi_next = k_reg - 10'sd1;
                end
            end
            default:
            begin
            end
        endcase
        if (skip)
        begin
            len_next = len_reg - 5'd1;
            res_wr   = (len_reg == 5'd1);
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mcl_reg       <= 5'(MAX_LEN);
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                mcl_reg <= cfg_wdata;
            end
            if (res_wr)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // Search datapath and result slot.
    always_ff @(posedge clk)
    begin
        len_reg <= len_next;
        lo_reg  <= lo_next;
        hi_reg  <= hi_next;
        if (state_reg == ST_BS)
        begin
            k_reg <= k_val;
        end
        if (state_reg == ST_OFFS)
        begin
            w_reg <= w_val;
        end
        if (start_dec)
        begin
            bits_reg <= q_data.bits;
            wlen_reg <= q_data.wlen;
        end
        if (res_wr)
        begin
            res_len_reg <= res_len;
            res_sym_reg <= res_sym;
        end
    end

    // Table memories: loads write, the sequencer reads.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && q_pop && q_data.kind == CMD_LOAD_ENTRY)
        begin
            cmem[q_data.idx] <= {q_data.codeword, q_data.sym};
        end
        if (state_reg == ST_IDLE && q_pop && q_data.kind == CMD_LOAD_OFFSET)
        begin
            omem[q_data.level] <= q_data.offset;
        end
        cmem_q   <= cmem[rd_addr];
        off_lo_q <= omem[len_reg];
        off_hi_q <= omem[len_reg + 5'd1];
    end

    a_res_slot: assert property (@(posedge clk) disable iff (!rst_n)
        res_wr |-> slot_free)
        else $error("result written while the slot is occupied");

    a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> (len_reg != 5'd0 && len_reg <= 5'(MAX_LEN)))
        else $error("probed length out of range");

    a_bs_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_BS && lo_reg <= hi_reg) |=> (state_reg == ST_CMP))
        else $error("binary search step lost");

endmodule

@@ sv/prefix_code_table_decoder.sv @@
`timescale 1ns / 1ps
// A load is applied by the back end when it is taken from the queue; a decode with
// nothing to probe gives a zero result at once, otherwise lengths are probed from the longest down.
// One decode at a time: the search sequencer over the single-port codeword table
// takes the next command from the queue only once the last decode is done.
// Reset: asynchronous, active low; queues empty, max_code_length returns to 16.
module prefix_code_table_decoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  req_type,
    input  logic [63:0] window_bits,
    input  logic [6:0]  window_len,
    input  logic [7:0]  entry_index,
    input  logic [15:0] entry_codeword,
    input  logic [7:0]  entry_symbol,
    input  logic [4:0]  offset_level,
    input  logic [8:0]  offset_value,
    input  logic        cfg_we,
    input  logic [4:0]  cfg_wdata,
    output logic        empty,
    input  logic        pop,
    output logic [4:0]  matched_len,
    output logic [7:0]  symbol
);
    import pcd_pkg::*;

    logic q_push;
    logic q_pop;
    logic q_empty;
    cmd_t q_wdata;
    cmd_t q_rdata;

    // Front end: classify each transfer.
    pcd_front u_front (
        .push           (push),
        .req_type       (req_type),
        .window_bits    (window_bits),
        .window_len     (window_len),
        .entry_index    (entry_index),
        .entry_codeword (entry_codeword),
        .entry_symbol   (entry_symbol),
        .offset_level   (offset_level),
        .offset_value   (offset_value),
        .q_full         (full),
        .q_push         (q_push),
        .q_data         (q_wdata)
    );

    // Command queue between the two halves.
    pcd_cmd_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data (q_wdata),
        .full    (full),
        .rd_en   (q_pop),
        .empty   (q_empty),
        .rd_data (q_rdata)
    );

    // Back end: table loads and the length-by-length search.
    pcd_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .q_empty     (q_empty),
        .q_data      (q_rdata),
        .q_pop       (q_pop),
        .empty       (empty),
        .pop         (pop),
        .matched_len (matched_len),
        .symbol      (symbol)
    );

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;
    import pcd_pkg::*;

    localparam logic [1:0] REQ_UNKNOWN = 2'd3;
    localparam int         DRAIN_CYCLES = 400;

    typedef struct {
        logic [1:0]  req;
        logic [63:0] bits;
        logic [6:0]  wlen;
        logic [7:0]  idx;
        logic [15:0] cw;
        logic [7:0]  sym;
        logic [4:0]  lvl;
        logic [8:0]  off;
    } request_t;

    typedef struct {
        logic [4:0] mlen;
        logic [7:0] sym;
    } decode_result_t;

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    logic [1:0]  req_type;
    logic [63:0] window_bits;
    logic [6:0]  window_len;
    logic [7:0]  entry_index;
    logic [15:0] entry_codeword;
    logic [7:0]  entry_symbol;
    logic [4:0]  offset_level;
    logic [8:0]  offset_value;
    logic        cfg_we;
    logic [4:0]  cfg_wdata;
    logic        empty;
    logic        pop;
    logic [4:0]  matched_len;
    logic [7:0]  symbol;

    prefix_code_table_decoder i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .req_type       (req_type),
        .window_bits    (window_bits),
        .window_len     (window_len),
        .entry_index    (entry_index),
        .entry_codeword (entry_codeword),
        .entry_symbol   (entry_symbol),
        .offset_level   (offset_level),
        .offset_value   (offset_value),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .empty          (empty),
        .pop            (pop),
        .matched_len    (matched_len),
        .symbol         (symbol)
    );

    // Shadow copy of the decoder's tables and register.
    logic [15:0] code_table [NUM_SYMBOLS];
    logic [7:0]  sym_table [NUM_SYMBOLS];
    logic [8:0]  start_table [OFFS_DEPTH];
    logic [4:0]  longest_len;

    // The codebook as loaded, used to build windows that hit real codewords.
    int          book_len [NUM_SYMBOLS];
    logic [15:0] book_code [NUM_SYMBOLS];
    int          book_size;

    request_t       pending_requests [$];
    decode_result_t expected_results [$];
    request_t       in_flight;
    int             mismatches;
    bit             send_idle_on;
    bit             recv_idle_on;
    int             send_gap;
    int             recv_gap;

    // Search the shadow table exactly as the decoder is meant to.
    function automatic decode_result_t decode_window(logic [63:0] bits, logic [6:0] wlen_in);
        decode_result_t res;
        int             wl;
        int             top;
        int             lo;
        int             hi;
        int             k;
        logic [63:0]    w;
        res.mlen = '0;
        res.sym  = '0;
        wl = (wlen_in > 64) ? 64 : int'(wlen_in);
        top = wl;
        if (top > longest_len)
            top = longest_len;
        if (top > MAX_LEN)
            top = MAX_LEN;
        for (int len = top; len > 0; len--)
        begin
            w  = (bits >> (wl - len)) & ((64'd1 << len) - 64'd1);
            lo = start_table[len];
            hi = start_table[len + 1];
            if (lo >= hi || hi > NUM_SYMBOLS)
                continue;
            hi = hi - 1;
            if (w < code_table[lo] || code_table[hi] < w)
                continue;
            while (lo <= hi)
            begin
                k = lo + (hi - lo) / 2;
                if (code_table[k] < w)
                    lo = k + 1;
                else if (code_table[k] > w)
                    hi = k - 1;
                else
                begin
                    res.mlen = len[4:0];
                    res.sym  = sym_table[k];
                    return res;
                end
            end
        end
        return res;
    endfunction

    // Apply one accepted transfer to the shadow state.
    function automatic void track_request(request_t r);
        case (r.req)
            REQ_DECODE:
            begin
                if (r.wlen == 0)
                    expected_results.push_back('{5'd0, 8'd0});
                else
                    expected_results.push_back(decode_window(r.bits, r.wlen));
            end
            REQ_LOAD_ENTRY:
            begin
                code_table[r.idx] = r.cw;
                sym_table[r.idx]  = r.sym;
            end
            REQ_LOAD_OFFSET:
            begin
                if (r.lvl < OFFS_DEPTH)
                    start_table[r.lvl] = r.off;
            end
            default: ;
        endcase
    endfunction

    function automatic request_t noise_request(logic [1:0] req);
        request_t r;
        r.req  = req;
        r.bits = {$urandom, $urandom};
        r.wlen = 7'($urandom);
        r.idx  = 8'($urandom);
        r.cw   = 16'($urandom);
        r.sym  = 8'($urandom);
        r.lvl  = 5'($urandom);
        r.off  = 9'($urandom);
        return r;
    endfunction

    task automatic queue_decode(logic [63:0] bits, logic [6:0] wlen);
        request_t r;
        r = noise_request(REQ_DECODE);
        r.bits = bits;
        r.wlen = wlen;
        pending_requests.push_back(r);
    endtask

    task automatic queue_entry(int idx, logic [15:0] cw, logic [7:0] sym);
        request_t r;
        r = noise_request(REQ_LOAD_ENTRY);
        r.idx = idx[7:0];
        r.cw  = cw;
        r.sym = sym;
        pending_requests.push_back(r);
    endtask

    task automatic queue_offset(logic [4:0] lvl, logic [8:0] off);
        request_t r;
        r = noise_request(REQ_LOAD_OFFSET);
        r.lvl = lvl;
        r.off = off;
        pending_requests.push_back(r);
    endtask

    // Build a random codebook, sorted and unique within each length, and queue
    // its loads. On the first call every table entry is written.
    task automatic load_codebook(bit fill_all, bit full_book);
        int          cnt;
        int          span;
        int          step;
        longint      c;
        int          lim;
        logic [8:0]  starts [OFFS_DEPTH];
        book_size = 0;
        starts[0] = 0;
        starts[1] = 0;
        for (int len = 1; len <= MAX_LEN; len++)
        begin
            lim = (len < 4) ? (1 << len) : (full_book ? 40 : 12);
            cnt = $urandom_range(0, lim);
            span = 1 << len;
            step = (span / (cnt + 1) > 1) ? span / (cnt + 1) : 1;
            c = $urandom_range(0, step - 1);
            for (int n = 0; n < cnt && c < span && book_size < NUM_SYMBOLS; n++)
            begin
                book_len[book_size]  = len;
                book_code[book_size] = c[15:0];
                queue_entry(book_size, c[15:0], 8'($urandom));
                book_size++;
                c = c + $urandom_range(1, 2 * step);
            end
            starts[len + 1] = book_size[8:0];
        end
        if (fill_all)
            for (int k = book_size; k < NUM_SYMBOLS; k++)
                queue_entry(k, 16'($urandom), 8'($urandom));
        for (int lvl = 0; lvl < OFFS_DEPTH; lvl++)
            queue_offset(lvl[4:0], starts[lvl]);
    endtask

    // A window that starts with a known codeword, with random bits after it
    // and random bits above the valid part.
    task automatic queue_hit_window();
        int          k;
        int          len;
        int          wl;
        logic [63:0] bits;
        if (book_size == 0)
        begin
            queue_decode({$urandom, $urandom}, 7'($urandom_range(1, 64)));
            return;
        end
        k   = $urandom_range(0, book_size - 1);
        len = book_len[k];
        wl  = $urandom_range(len, 64);
        bits = {$urandom, $urandom};
        if (wl < 64)
            bits[wl - 1 -: 1] = bits[wl - 1 -: 1];
        for (int b = 0; b < len; b++)
            bits[wl - len + b] = book_code[k][b];
        queue_decode(bits, wl[6:0]);
    endtask

    task automatic queue_random_items(int count, bit allow_bad);
        int pick;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
                queue_hit_window();
            else if (pick < 88)
                queue_decode({$urandom, $urandom}, 7'($urandom_range(0, 127)));
            else if (pick < 94 && book_size > 0)
            begin
                // Rewrite the symbol of an existing codeword.
                int k;
                k = $urandom_range(0, book_size - 1);
                queue_entry(k, book_code[k], 8'($urandom));
            end
            else if (pick < 97)
            begin
                // Offset loads beyond the table are dropped by the block.
                pending_requests.push_back(noise_request(REQ_LOAD_OFFSET));
                pending_requests[$].lvl = 5'($urandom_range(OFFS_DEPTH, 31));
            end
            else if (allow_bad)
                pending_requests.push_back(noise_request(REQ_LOAD_OFFSET));
            else
                pending_requests.push_back(noise_request(REQ_UNKNOWN));
        end
    endtask

    // Wait until every transfer has gone and every result has come back.
    task automatic wait_quiet();
        while (pending_requests.size() != 0 || push || expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_longest_len(logic [4:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        longest_len = value;
    endtask

    // Clock
    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #4 clk = ~clk;
    end

    // Driver: presents the next pending request, after a random pause when pauses are enabled.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push           <= 1'b0;
            req_type       <= '0;
            window_bits    <= '0;
            window_len     <= '0;
            entry_index    <= '0;
            entry_codeword <= '0;
            entry_symbol   <= '0;
            offset_level   <= '0;
            offset_value   <= '0;
            send_gap       = 0;
        end
        else
        begin
            if (push && !full)
                track_request(in_flight);
            if (!push || !full)
            begin
                if (send_gap > 0)
                begin
                    send_gap = send_gap - 1;
                    push <= 1'b0;
                end
                else if (pending_requests.size() != 0)
                begin
                    in_flight = pending_requests.pop_front();
                    req_type       <= in_flight.req;
                    window_bits    <= in_flight.bits;
                    window_len     <= in_flight.wlen;
                    entry_index    <= in_flight.idx;
                    entry_codeword <= in_flight.cw;
                    entry_symbol   <= in_flight.sym;
                    offset_level   <= in_flight.lvl;
                    offset_value   <= in_flight.off;
                    push           <= 1'b1;
                    send_gap = send_idle_on ? $urandom_range(0, 4) : 0;
                end
                else
                    push <= 1'b0;
            end
        end
    end

    // Monitor: takes results, with random stalls when enabled, and checks each result.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pop <= 1'b0;
            recv_gap = 0;
        end
        else if (pop && !empty)
        begin
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result len=%0d sym=%0d", matched_len, symbol);
            end
            else
            begin
                decode_result_t e;
                e = expected_results.pop_front();
                if (matched_len !== e.mlen || symbol !== e.sym)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: expected len=%0d sym=%0d, got len=%0d sym=%0d",
                                 e.mlen, e.sym, matched_len, symbol);
                end
            end
            recv_gap = recv_idle_on ? $urandom_range(0, 4) : 0;
            if (recv_gap > 0)
            begin
                recv_gap = recv_gap - 1;
                pop <= 1'b0;
            end
            else
                pop <= 1'b1;
        end
        else if (!pop)
        begin
            if (recv_gap > 0)
                recv_gap = recv_gap - 1;
            else
                pop <= 1'b1;
        end
    end

    // Stimulus, in phases separated by register writes.
    initial
    begin
        logic [4:0] settings [8];
        mismatches   = 0;
        send_idle_on = 1'b0;
        recv_idle_on = 1'b0;
        longest_len  = 5'd16;
        book_size    = 0;
        for (int k = 0; k < NUM_SYMBOLS; k++)
        begin
            code_table[k] = '0;
            sym_table[k]  = '0;
        end
        for (int k = 0; k < OFFS_DEPTH; k++)
            start_table[k] = '0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        rst_n     = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: fill the tables, then the corner cases at reset length.
        load_codebook(1'b1, 1'b0);
        queue_decode({$urandom, $urandom}, 7'd0);
        queue_decode(64'hFFFF_FFFF_FFFF_FFFF, 7'd64);
        queue_decode(64'h0, 7'd64);
        queue_decode({$urandom, $urandom}, 7'd127);
        queue_decode({$urandom, $urandom}, 7'd65);
        queue_decode(64'h1, 7'd1);
        queue_decode(64'h0, 7'd1);
        pending_requests.push_back(noise_request(REQ_UNKNOWN));
        queue_offset(5'd31, 9'h1FF);
        queue_offset(5'd18, 9'd0);
        for (int n = 0; n < 6; n++)
            queue_hit_window();
        wait_quiet();

        settings = '{5'd0, 5'd1, 5'd31, 5'd16, 5'd5, 5'd17, 5'd9, 5'd16};
        for (int ph = 0; ph < 8; ph++)
        begin
            write_longest_len(ph == 6 ? 5'($urandom_range(1, 16)) : settings[ph]);
            send_idle_on = (ph % 3) != 1;
            recv_idle_on = (ph % 4) != 2;
            load_codebook(1'b0, ph == 3);
            if (ph == 5)
            begin
                // Malformed start offsets, including values past the table.
                for (int n = 0; n < 8; n++)
                    queue_offset(5'($urandom_range(0, OFFS_DEPTH - 1)), 9'($urandom));
                queue_offset(5'd17, 9'd256);
            end
            queue_random_items(70, ph == 5);
            wait_quiet();
        end

        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Guard against a hung handshake.
    initial
    begin
        #60ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

@@ prefix_code_table_decoder.f @@
sv/pcd_pkg.sv
sv/pcd_front.sv
sv/pcd_cmd_fifo.sv
sv/pcd_back.sv
sv/prefix_code_table_decoder.sv
tb/sv/tb_top.sv
